// ----- rtl/core/ctcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctcb_pkg
// Shared types and constants of the sparse column pointer builder.
// ----------------------------------------------------------------------------
package ctcb_pkg;

   typedef logic [1:0] action_type;

   localparam action_type ACT_CLEAR    = 2'd0;
   localparam action_type ACT_ADD      = 2'd1;
   localparam action_type ACT_FINALIZE = 2'd2;
   localparam action_type ACT_READ     = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam int ROW_CFG_W    = 21;
   localparam int COL_CFG_W    = 11;
   localparam int PCOL_W       = 11;
   localparam int ROW_VALUE_W  = 20;
   localparam int COL_VALUE_W  = 10;
   localparam int WORD_W       = 32;

   localparam logic [ROW_CFG_W-1:0] ROWS_LIMIT = 21'd1048576;

   typedef struct packed {
      action_type action;
      logic       read_ok;
   } cmd_type;

endpackage

// ----- rtl/core/coo_to_csc_builder_unit.sv -----
// ----------------------------------------------------------------------------
// coo_to_csc_builder_unit
// Builds compressed-sparse-column pointers from column-major linear indices.
// ----------------------------------------------------------------------------
// The front end accepts items into a two-entry queue; the back end executes
// them one at a time against a single-port column store of MAX_COLUMNS+1
// words. After reset the store is swept to zero, during which no item is
// accepted; configuration writes are taken at any time. An add item runs
// through a divider that yields one quotient bit per cycle and splits the
// linear index into column and row. A clear item sweeps the whole store to
// zero, a finalize item walks words 0 to columns with a read then a write
// of each, and a read item fetches one word. The result register lets the
// next item be accepted while a result waits to be taken.
module coo_to_csc_builder_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctcb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [INDEX_WIDTH-1:0]             req_linear_index,
   input  logic [ctcb_pkg::PCOL_W-1:0]        req_pointer_column,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_result_kind,
   output logic [ctcb_pkg::ROW_VALUE_W-1:0]   rsp_row_value,
   output logic [ctcb_pkg::COL_VALUE_W-1:0]   rsp_column_value,
   output logic [ctcb_pkg::WORD_W-1:0]        rsp_pointer_value,
   output logic                               rsp_out_of_range
);
   import ctcb_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS + 1);

   logic                   init_busy;
   logic                   queue_full;
   logic                   push;
   cmd_type                push_cmd;
   logic [INDEX_WIDTH-1:0] push_lin;
   logic [ADDR_W-1:0]      push_addr;
   logic                   head_valid;
   cmd_type                head_cmd;
   logic [INDEX_WIDTH-1:0] head_lin;
   logic [ADDR_W-1:0]      head_addr;
   logic                   pop;
   logic [ROW_CFG_W-1:0]   rows_eff;
   logic [ADDR_W-1:0]      cols_eff;

   ctcb_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .INDEX_WIDTH (INDEX_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_linear_index   (req_linear_index),
      .req_pointer_column (req_pointer_column),
      .init_busy          (init_busy),
      .queue_full         (queue_full),
      .push               (push),
      .push_cmd           (push_cmd),
      .push_lin           (push_lin),
      .push_addr          (push_addr),
      .rows_eff           (rows_eff),
      .cols_eff           (cols_eff)
   );

   ctcb_queue #(
      .LIN_W  (INDEX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_lin   (push_lin),
      .push_addr  (push_addr),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_lin   (head_lin),
      .head_addr  (head_addr),
      .pop        (pop)
   );

   ctcb_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .INDEX_WIDTH (INDEX_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .head_lin          (head_lin),
      .head_addr         (head_addr),
      .pop               (pop),
      .rows_eff          (rows_eff),
      .cols_eff          (cols_eff),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_row_value     (rsp_row_value),
      .rsp_column_value  (rsp_column_value),
      .rsp_pointer_value (rsp_pointer_value),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

// ----- rtl/core/ctcb_queue.sv -----
// ----------------------------------------------------------------------------
// ctcb_queue
// Two-entry queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module ctcb_queue #(
   parameter int LIN_W  = 32,
   parameter int ADDR_W = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctcb_pkg::cmd_type   push_cmd,
   input  logic [LIN_W-1:0]    push_lin,
   input  logic [ADDR_W-1:0]   push_addr,
   output logic                full,
   output logic                head_valid,
   output ctcb_pkg::cmd_type   head_cmd,
   output logic [LIN_W-1:0]    head_lin,
   output logic [ADDR_W-1:0]   head_addr,
   input  logic                pop
);
   import ctcb_pkg::*;

   cmd_type             cmd_ff  [2];
   logic [LIN_W-1:0]    lin_ff  [2];
   logic [ADDR_W-1:0]   addr_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= push_cmd;
         lin_ff[wr_ptr_ff]  <= push_lin;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = cmd_ff[rd_ptr_ff];
   assign head_lin   = lin_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/ctcb_front.sv -----
// ----------------------------------------------------------------------------
// ctcb_front
// Configuration registers, item acceptance and classification into the queue.
// ----------------------------------------------------------------------------
module ctcb_front #(
   parameter int MAX_COLUMNS = 1024,
   parameter int INDEX_WIDTH = 32,
   parameter int ADDR_W      = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctcb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [INDEX_WIDTH-1:0]             req_linear_index,
   input  logic [ctcb_pkg::PCOL_W-1:0]        req_pointer_column,
   input  logic                               init_busy,
   input  logic                               queue_full,
   output logic                               push,
   output ctcb_pkg::cmd_type                  push_cmd,
   output logic [INDEX_WIDTH-1:0]             push_lin,
   output logic [ADDR_W-1:0]                  push_addr,
   output logic [ctcb_pkg::ROW_CFG_W-1:0]     rows_eff,
   output logic [ADDR_W-1:0]                  cols_eff
);
   import ctcb_pkg::*;

   logic [ROW_CFG_W-1:0] row_count_ff, row_count_in;
   logic [COL_CFG_W-1:0] column_count_ff, column_count_in;

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_valid) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_in = csr_wdata[ROW_CFG_W-1:0];
         end else if (csr_index == CSR_COLUMN_COUNT) begin
            column_count_in = csr_wdata[COL_CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_CFG_W'(1);
         column_count_ff <= COL_CFG_W'(1);
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = ROW_CFG_W'(1);
      end else if (row_count_ff > ROWS_LIMIT) begin
         rows_eff = ROWS_LIMIT;
      end else begin
         rows_eff = row_count_ff;
      end
      if (column_count_ff == '0) begin
         cols_eff = ADDR_W'(1);
      end else if (32'(column_count_ff) > 32'(MAX_COLUMNS)) begin
         cols_eff = ADDR_W'(MAX_COLUMNS);
      end else begin
         cols_eff = ADDR_W'(column_count_ff);
      end
   end

   assign req_ready        = !queue_full && !init_busy;
   assign push             = req_valid && req_ready;
   assign push_cmd.action  = req_action;
   assign push_cmd.read_ok = (32'(req_pointer_column) <= 32'(MAX_COLUMNS));
   assign push_lin         = req_linear_index;
   assign push_addr        = ADDR_W'(req_pointer_column);

endmodule

// ----- rtl/core/ctcb_back.sv -----
// ----------------------------------------------------------------------------
// ctcb_back
// Executes queued items: column store sweeps, iterative division, updates
// and reads, with a registered result stage.
// ----------------------------------------------------------------------------
module ctcb_back #(
   parameter int MAX_COLUMNS = 1024,
   parameter int INDEX_WIDTH = 32,
   parameter int ADDR_W      = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  ctcb_pkg::cmd_type                  head_cmd,
   input  logic [INDEX_WIDTH-1:0]             head_lin,
   input  logic [ADDR_W-1:0]                  head_addr,
   output logic                               pop,
   input  logic [ctcb_pkg::ROW_CFG_W-1:0]     rows_eff,
   input  logic [ADDR_W-1:0]                  cols_eff,
   output logic                               init_busy,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_result_kind,
   output logic [ctcb_pkg::ROW_VALUE_W-1:0]   rsp_row_value,
   output logic [ctcb_pkg::COL_VALUE_W-1:0]   rsp_column_value,
   output logic [ctcb_pkg::WORD_W-1:0]        rsp_pointer_value,
   output logic                               rsp_out_of_range
);
   import ctcb_pkg::*;

   localparam int PW   = ROW_CFG_W + ADDR_W;
   localparam int CMPW = (INDEX_WIDTH > PW) ? INDEX_WIDTH : PW;
   localparam int SW   = $clog2(INDEX_WIDTH + 1);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_CLEAR  = 4'd2;
   localparam logic [3:0] ST_LIMIT  = 4'd3;
   localparam logic [3:0] ST_CHECK  = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_UPD_RD = 4'd6;
   localparam logic [3:0] ST_UPD_WR = 4'd7;
   localparam logic [3:0] ST_FIN_RD = 4'd8;
   localparam logic [3:0] ST_FIN_WR = 4'd9;
   localparam logic [3:0] ST_READ   = 4'd10;
   localparam logic [3:0] ST_EMIT   = 4'd11;

   logic [WORD_W-1:0] column_store [0:MAX_COLUMNS];
   logic [WORD_W-1:0] mem_q_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [3:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [INDEX_WIDTH-1:0] quot_ff, quot_in;
   logic [PW-1:0]          limit_ff, limit_in;
   logic [ROW_CFG_W-1:0]   rem_ff, rem_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [WORD_W-1:0]      running_ff, running_in;
   logic                   read_ok_ff, read_ok_in;

   logic                   res_kind_ff, res_kind_in;
   logic [ROW_VALUE_W-1:0] res_row_ff, res_row_in;
   logic [COL_VALUE_W-1:0] res_col_ff, res_col_in;
   logic [WORD_W-1:0]      res_ptr_ff, res_ptr_in;
   logic                   res_oor_ff, res_oor_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [ROW_VALUE_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_VALUE_W-1:0] rsp_col_ff, rsp_col_in;
   logic [WORD_W-1:0]      rsp_ptr_ff, rsp_ptr_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   logic                   out_free;
   logic [ROW_CFG_W-1:0]   shifted;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign shifted  = {rem_ff[ROW_CFG_W-2:0], quot_ff[INDEX_WIDTH-1]};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      quot_in      = quot_ff;
      limit_in     = limit_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      running_in   = running_ff;
      read_ok_in   = read_ok_ff;
      res_kind_in  = res_kind_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      res_ptr_in   = res_ptr_ff;
      res_oor_in   = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_oor_in   = rsp_oor_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = idx_ff;
      mem_raddr    = idx_ff;
      mem_wdata    = '0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
            if (idx_ff == ADDR_W'(MAX_COLUMNS)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head_cmd.action)
                  ACT_CLEAR: begin
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_ADD: begin
                     quot_in  = head_lin;
                     state_in = ST_LIMIT;
                  end
                  ACT_FINALIZE: begin
                     idx_in     = '0;
                     running_in = '0;
                     state_in   = ST_FIN_RD;
                  end
                  default: begin
                     mem_re     = 1'b1;
                     mem_raddr  = head_addr;
                     read_ok_in = head_cmd.read_ok;
                     state_in   = ST_READ;
                  end
               endcase
            end
         end
         ST_LIMIT: begin
            limit_in = PW'(rows_eff) * PW'(cols_eff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (CMPW'(quot_ff) >= CMPW'(limit_ff)) begin
               res_kind_in = 1'b0;
               res_row_in  = '0;
               res_col_in  = '0;
               res_ptr_in  = '0;
               res_oor_in  = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               rem_in   = '0;
               step_in  = SW'(INDEX_WIDTH);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (shifted >= rows_eff) begin
               rem_in  = shifted - rows_eff;
               quot_in = {quot_ff[INDEX_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               quot_in = {quot_ff[INDEX_WIDTH-2:0], 1'b0};
            end
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(quot_ff);
            state_in  = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            mem_we      = 1'b1;
            mem_waddr   = ADDR_W'(quot_ff);
            mem_wdata   = mem_q_ff + WORD_W'(1);
            res_kind_in = 1'b0;
            res_row_in  = ROW_VALUE_W'(rem_ff);
            res_col_in  = COL_VALUE_W'(quot_ff);
            res_ptr_in  = '0;
            res_oor_in  = 1'b0;
            state_in    = ST_EMIT;
         end
         ST_FIN_RD: begin
            mem_re   = 1'b1;
            state_in = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            mem_we     = 1'b1;
            mem_wdata  = running_ff;
            running_in = running_ff + mem_q_ff;
            if (idx_ff == cols_eff) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_FIN_RD;
            end
         end
         ST_READ: begin
            res_kind_in = 1'b1;
            res_row_in  = '0;
            res_col_in  = '0;
            res_ptr_in  = read_ok_ff ? mem_q_ff : '0;
            res_oor_in  = 1'b0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_row_in   = res_row_ff;
               rsp_col_in   = res_col_ff;
               rsp_ptr_in   = res_ptr_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      limit_ff    <= limit_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      running_ff  <= running_in;
      read_ok_ff  <= read_ok_in;
      res_kind_ff <= res_kind_in;
      res_row_ff  <= res_row_in;
      res_col_ff  <= res_col_in;
      res_ptr_ff  <= res_ptr_in;
      res_oor_ff  <= res_oor_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_ptr_ff  <= rsp_ptr_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         column_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= column_store[mem_raddr];
      end
   end

   assign init_busy         = (state_ff == ST_INIT);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_row_value     = rsp_row_ff;
   assign rsp_column_value  = rsp_col_ff;
   assign rsp_pointer_value = rsp_ptr_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

endmodule

// ----- tb/coo_to_csc_builder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_to_csc_builder_checker
// Watches the configuration, request and response channels of the sparse
// column pointer builder. It keeps its own column word store and register
// copies, works out the reply of every accepted add and read item, and compares each
// accepted response field by field with the oldest reply still owed.
// ----------------------------------------------------------------------------
module coo_to_csc_builder_checker #(
   parameter int MAX_COLUMNS = 1024,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ctcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctcb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [INDEX_WIDTH-1:0]             req_linear_index,
   input  logic [ctcb_pkg::PCOL_W-1:0]        req_pointer_column,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_result_kind,
   input  logic [ctcb_pkg::ROW_VALUE_W-1:0]   rsp_row_value,
   input  logic [ctcb_pkg::COL_VALUE_W-1:0]   rsp_column_value,
   input  logic [ctcb_pkg::WORD_W-1:0]        rsp_pointer_value,
   input  logic                               rsp_out_of_range,
   output int                                 mismatch_total,
   output int                                 replies_owed
);
   import ctcb_pkg::*;

   typedef struct packed {
      logic                   result_kind;
      logic [ROW_VALUE_W-1:0] row_value;
      logic [COL_VALUE_W-1:0] column_value;
      logic [WORD_W-1:0]      pointer_value;
      logic                   out_of_range;
   } csc_reply_type;

   csc_reply_type        csc_replies[$];
   logic [WORD_W-1:0]    column_words [0:MAX_COLUMNS];
   logic [ROW_CFG_W-1:0] row_cfg;
   logic [COL_CFG_W-1:0] col_cfg;
   int                   fail_total = 0;

   task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (fail_total < 100) begin
         $display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      fail_total++;
   endtask

   task automatic run_action(input action_type act, input logic [INDEX_WIDTH-1:0] lin,
                             input logic [PCOL_W-1:0] pcol, output bit has_reply,
                             output csc_reply_type reply);
      longint unsigned   rows;
      longint unsigned   cols;
      longint unsigned   lin_value;
      longint unsigned   col;
      longint unsigned   row;
      logic [WORD_W-1:0] running;
      logic [WORD_W-1:0] held;
      rows = row_cfg;
      if (row_cfg == '0) begin
         rows = 1;
      end else if (row_cfg > ROWS_LIMIT) begin
         rows = ROWS_LIMIT;
      end
      cols = col_cfg;
      if (col_cfg == '0) begin
         cols = 1;
      end else if (col_cfg > MAX_COLUMNS) begin
         cols = MAX_COLUMNS;
      end
      lin_value = 64'(lin);
      reply = '0;
      has_reply = 1'b0;
      case (act)
         ACT_CLEAR: begin
            for (int i = 0; i <= MAX_COLUMNS; i++) column_words[i] = '0;
         end
         ACT_ADD: begin
            has_reply = 1'b1;
            if (lin_value >= rows * cols) begin
               reply.out_of_range = 1'b1;
            end else begin
               col = lin_value / rows;
               row = lin_value - col * rows;
               column_words[col] = column_words[col] + 32'd1;
               reply.row_value = row[ROW_VALUE_W-1:0];
               reply.column_value = col[COL_VALUE_W-1:0];
            end
         end
         ACT_FINALIZE: begin
            running = '0;
            for (longint unsigned i = 0; i <= cols; i++) begin
               held = column_words[i];
               column_words[i] = running;
               running = running + held;
            end
         end
         default: begin
            has_reply = 1'b1;
            reply.result_kind = 1'b1;
            if (pcol <= MAX_COLUMNS) begin
               reply.pointer_value = column_words[pcol];
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      bit            has_reply;
      csc_reply_type reply;
      csc_reply_type want;
      if (reset) begin
         for (int i = 0; i <= MAX_COLUMNS; i++) column_words[i] = '0;
         row_cfg = 1;
         col_cfg = 1;
         csc_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (csc_replies.size() == 0) begin
               note_mismatch("response with no item outstanding", rsp_pointer_value, '0);
            end else begin
               want = csc_replies.pop_front();
               if (rsp_result_kind !== want.result_kind) begin
                  note_mismatch("result_kind", 32'(rsp_result_kind), 32'(want.result_kind));
               end
               if (rsp_row_value !== want.row_value) begin
                  note_mismatch("row_value", 32'(rsp_row_value), 32'(want.row_value));
               end
               if (rsp_column_value !== want.column_value) begin
                  note_mismatch("column_value", 32'(rsp_column_value),
                                32'(want.column_value));
               end
               if (rsp_pointer_value !== want.pointer_value) begin
                  note_mismatch("pointer_value", rsp_pointer_value, want.pointer_value);
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  note_mismatch("out_of_range", 32'(rsp_out_of_range),
                                32'(want.out_of_range));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_COUNT:    row_cfg = csr_wdata[ROW_CFG_W-1:0];
               CSR_COLUMN_COUNT: col_cfg = csr_wdata[COL_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            run_action(req_action, req_linear_index, req_pointer_column, has_reply, reply);
            if (has_reply) csc_replies.push_back(reply);
         end
      end
      replies_owed <= csc_replies.size();
      mismatch_total <= fail_total;
   end

endmodule

// ----- tb/coo_to_csc_builder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_to_csc_builder_unit_tb
// Drives the sparse column pointer builder with a directed opening and then
// rounds of clear, entry, finalize and read items under several row and
// column settings and idle patterns; the checker judges every response.
// ----------------------------------------------------------------------------
module coo_to_csc_builder_unit_tb;
   import ctcb_pkg::*;

   localparam int MAX_COLUMNS   = 1024;
   localparam int INDEX_WIDTH   = 32;
   localparam int ITEM_TOTAL    = 1700;
   localparam int SETTLE_CYCLES = 2 * (MAX_COLUMNS + 1) + 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_HI = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   action_type               req_action = ACT_CLEAR;
   logic [INDEX_WIDTH-1:0]   req_linear_index = '0;
   logic [PCOL_W-1:0]        req_pointer_column = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_result_kind;
   logic [ROW_VALUE_W-1:0]   rsp_row_value;
   logic [COL_VALUE_W-1:0]   rsp_column_value;
   logic [WORD_W-1:0]        rsp_pointer_value;
   logic                     rsp_out_of_range;

   int          mismatch_total;
   int          replies_owed;
   int          send_idle = 34;
   int          recv_idle = 56;
   int          items_sent = 0;
   int unsigned rows_in_use = 1;
   int unsigned cols_in_use = 1;

   coo_to_csc_builder_unit #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_linear_index   (req_linear_index),
      .req_pointer_column (req_pointer_column),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_row_value      (rsp_row_value),
      .rsp_column_value   (rsp_column_value),
      .rsp_pointer_value  (rsp_pointer_value),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   coo_to_csc_builder_checker #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) csc_watch (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_linear_index   (req_linear_index),
      .req_pointer_column (req_pointer_column),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_row_value      (rsp_row_value),
      .rsp_column_value   (rsp_column_value),
      .rsp_pointer_value  (rsp_pointer_value),
      .rsp_out_of_range   (rsp_out_of_range),
      .mismatch_total     (mismatch_total),
      .replies_owed       (replies_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic issue(input action_type act, input int unsigned lin,
                        input int unsigned pcol);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_linear_index <= INDEX_WIDTH'(lin);
      req_pointer_column <= pcol[PCOL_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_shape(input logic [CSR_DATA_W-1:0] rows_word,
                            input logic [CSR_DATA_W-1:0] cols_word, input bit spare);
      write_csr(CSR_ROW_COUNT, rows_word);
      write_csr(CSR_COLUMN_COUNT, cols_word);
      if (spare) begin
         write_csr(CSR_RESERVED_LO, $urandom);
         write_csr(CSR_RESERVED_HI, $urandom);
      end
      csr_valid <= 1'b0;
      rows_in_use = rows_word[ROW_CFG_W-1:0];
      if (rows_in_use == 0) rows_in_use = 1;
      if (rows_in_use > ROWS_LIMIT) rows_in_use = ROWS_LIMIT;
      cols_in_use = cols_word[COL_CFG_W-1:0];
      if (cols_in_use == 0) cols_in_use = 1;
      if (cols_in_use > MAX_COLUMNS) cols_in_use = MAX_COLUMNS;
   endtask

   task automatic run_round();
      int unsigned rows_pick;
      int unsigned cols_pick;
      int unsigned pick;
      int unsigned span;
      int          n_adds;
      int          n_reads;
      case ($urandom_range(9))
         0:       rows_pick = 1;
         1:       rows_pick = ROWS_LIMIT;
         2:       rows_pick = $urandom_range(2097151, 1048577);
         3:       rows_pick = 0;
         4, 5, 6: rows_pick = $urandom_range(16, 2);
         default: rows_pick = $urandom_range(1048576, 1);
      endcase
      case ($urandom_range(9))
         0:       cols_pick = 1;
         1:       cols_pick = MAX_COLUMNS;
         2:       cols_pick = 0;
         3:       cols_pick = $urandom_range(2047, 1025);
         default: cols_pick = $urandom_range(32, 1);
      endcase
      set_shape(($urandom & 32'hFFE0_0000) | rows_pick,
                ($urandom & 32'hFFFF_F800) | cols_pick, $urandom_range(3) == 0);
      span = rows_in_use * cols_in_use;
      if ($urandom_range(9) < 7) issue(ACT_CLEAR, $urandom, $urandom);
      n_adds = $urandom_range(50, 20);
      for (int k = 0; k < n_adds; k++) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            issue(ACT_ADD, $urandom_range(cols_in_use - 1, 0) * rows_in_use
                  + $urandom_range(rows_in_use - 1, 0), $urandom);
         end else if (pick < 80) begin
            issue(ACT_ADD, span - 1 + $urandom_range(1), $urandom);
         end else if (pick < 88) begin
            issue(ACT_ADD, $urandom, $urandom);
         end else if (pick < 96) begin
            issue(ACT_READ, $urandom, $urandom_range(cols_in_use, 0));
         end else begin
            issue(action_type'($urandom_range(3)), $urandom, $urandom_range(2047));
         end
      end
      if ($urandom_range(19) < 17) issue(ACT_FINALIZE, $urandom, $urandom);
      if ($urandom_range(9) < 2) issue(ACT_FINALIZE, $urandom, $urandom);
      repeat ($urandom_range(3)) begin
         issue(ACT_ADD, $urandom_range(cols_in_use - 1, 0) * rows_in_use
               + $urandom_range(rows_in_use - 1, 0), $urandom);
      end
      n_reads = $urandom_range(12, 4);
      repeat (n_reads) begin
         if ($urandom_range(9) < 8) begin
            issue(ACT_READ, $urandom, $urandom_range(cols_in_use, 0));
         end else begin
            issue(ACT_READ, $urandom, $urandom_range(2047));
         end
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Power-on shape of one row by one column.
      issue(ACT_READ, 0, 0);
      issue(ACT_ADD, 0, 0);
      issue(ACT_ADD, 1, 0);
      issue(ACT_ADD, 32'hFFFF_FFFF, 32'h7FF);
      issue(ACT_READ, 0, 0);
      issue(ACT_READ, 0, 2047);
      issue(ACT_FINALIZE, 0, 0);
      issue(ACT_READ, 0, 1);
      issue(ACT_READ, 0, MAX_COLUMNS);
      drain();

      // Both registers above their limits, then repeated finalize until
      // the prefix sums wrap around.
      set_shape(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      issue(ACT_CLEAR, 0, 0);
      issue(ACT_ADD, 32'h3FFF_FFFF, 0);
      issue(ACT_ADD, 32'h4000_0000, 0);
      issue(ACT_ADD, 32'h0010_0000, 0);
      issue(ACT_ADD, 0, 0);
      repeat (5) issue(ACT_FINALIZE, 0, 0);
      issue(ACT_READ, 0, MAX_COLUMNS);
      issue(ACT_READ, 0, 512);
      issue(ACT_READ, 0, 1023);
      drain();

      // Zero in both registers counts as one.
      set_shape(32'h0, 32'h0, 1'b0);
      issue(ACT_ADD, 0, 0);
      issue(ACT_ADD, 1, 0);
      issue(ACT_READ, 0, 0);
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle = 34;
               recv_idle = 56;
            end
            1: begin
               send_idle = 56;
               recv_idle = 34;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         while (items_sent < (mode + 1) * ITEM_TOTAL / 3) run_round();
      end

      if (mismatch_total == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
